FILE: hdl/k_way_merge_selector_macros.svh
// Assertion macros shared by the merge selector RTL.
`ifndef K_WAY_MERGE_SELECTOR_MACROS_SVH
`define K_WAY_MERGE_SELECTOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define KWM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define KWM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/kwm_pkg.sv
// Types and constants of the k-way merge selector.
package kwm_pkg;

   localparam int WAYS      = 8;
   localparam int RUN_DEPTH = 64;

   localparam int WAY_W  = 3;
   localparam int CFG_W  = 4;
   localparam int VAL_W  = 32;
   localparam int PTR_W  = $clog2(RUN_DEPTH);
   localparam int CNT_W  = $clog2(RUN_DEPTH + 1);
   localparam int SUM_W  = $clog2(2 * RUN_DEPTH);
   localparam int ADDR_W = $clog2(WAYS * RUN_DEPTH);

   localparam logic [CFG_W-1:0] ACTIVE_WAYS_RESET = CFG_W'(8);

   typedef enum logic [1:0] {
      CMD_PUSH  = 2'd0,
      CMD_POP   = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PUSH,
      S_CLEAR,
      S_SCAN,
      S_LAST,
      S_TAKE,
      S_DONE
   } state_type;

endpackage

FILE: hdl/kwm_channels.sv
// Request and response channel interfaces of the merge selector.
interface kwm_req_if import kwm_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [1:0]              cmd;
   logic [WAY_W-1:0]        run_index;
   logic signed [VAL_W-1:0] value;

   modport source (output valid, cmd, run_index, value, input ready);
   modport sink   (input valid, cmd, run_index, value, output ready);
endinterface

interface kwm_rsp_if import kwm_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [VAL_W-1:0] result_value;
   logic [WAY_W-1:0]        source_run;
   logic [1:0]              status;

   modport source (output valid, result_value, source_run, status, input ready);
   modport sink   (input valid, result_value, source_run, status, output ready);
endinterface

FILE: hdl/kwm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kwm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/k_way_merge_selector.sv
// Sequence: push and clear pass through S_PUSH or S_CLEAR and a no-op goes straight to S_DONE,
// which registers the response; a pop scans the k effective active ways (1..8) in S_SCAN,
// then checks in S_LAST, takes the best head in S_TAKE unless all runs are empty, and ends in
// S_DONE; the runs are walked one per cycle with one read and one compare, and requests are taken in S_IDLE only.
// The next request is taken while the last response waits; a held response stalls the next.
// Reset (synchronous) empties all runs, sets active ways to 8 and drops any response.
`include "k_way_merge_selector_macros.svh"

module k_way_merge_selector import kwm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   kwm_req_if.sink          req_if,
   kwm_rsp_if.source        rsp_if,
   input  logic             csr_wr_en,
   input  logic [CFG_W-1:0] csr_wr_data
);

   state_type          state_ff, state_in;
   logic [WAY_W-1:0]   run_ff, run_in;
   logic [VAL_W-1:0]   value_ff, value_in;
   logic [WAY_W-1:0]   scan_ff, scan_in;
   logic               cand_valid_ff, cand_valid_in;
   logic [WAY_W-1:0]   cand_way_ff, cand_way_in;
   logic               found_ff, found_in;
   logic [WAY_W-1:0]   best_way_ff, best_way_in;
   logic [VAL_W-1:0]   best_val_ff, best_val_in;
   logic [VAL_W-1:0]   res_value_ff, res_value_in;
   logic [WAY_W-1:0]   res_run_ff, res_run_in;
   status_type         res_status_ff, res_status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]   rsp_value_ff, rsp_value_in;
   logic [WAY_W-1:0]   rsp_run_ff, rsp_run_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [PTR_W-1:0]   head_ff [WAYS];
   logic [PTR_W-1:0]   head_in [WAYS];
   logic [CNT_W-1:0]   count_ff [WAYS];
   logic [CNT_W-1:0]   count_in [WAYS];
   logic [CFG_W-1:0]   active_ways_ff, active_ways_in;

   logic [CFG_W-1:0]   k_ways;
   logic [WAY_W-1:0]   k_last;
   logic [WAY_W-1:0]   sel_idx;
   logic [PTR_W-1:0]   sel_head;
   logic [CNT_W-1:0]   sel_count;
   logic [SUM_W-1:0]   slot_sum;
   logic [PTR_W-1:0]   slot;
   logic               ram_we;
   logic [ADDR_W-1:0]  ram_waddr;
   logic               ram_re;
   logic [ADDR_W-1:0]  ram_raddr;
   logic [VAL_W-1:0]   ram_rdata;

   kwm_ram #(
      .WIDTH (VAL_W),
      .DEPTH (WAYS * RUN_DEPTH)
   ) u_run_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (value_ff),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Effective number of ways: zero reads as one, saturate at WAYS.
   always_comb begin
      if (active_ways_ff == '0) begin
         k_ways = CFG_W'(1);
      end else if (active_ways_ff > CFG_W'(WAYS)) begin
         k_ways = CFG_W'(WAYS);
      end else begin
         k_ways = active_ways_ff;
      end
   end

   assign k_last = WAY_W'(k_ways - CFG_W'(1));

   always_comb begin
      case (state_ff)
         S_PUSH:  sel_idx = run_ff;
         S_SCAN:  sel_idx = scan_ff;
         S_TAKE:  sel_idx = best_way_ff;
         default: sel_idx = '0;
      endcase
   end

   assign sel_head  = head_ff[sel_idx];
   assign sel_count = count_ff[sel_idx];

   // Tail slot of the ring: head + count stays below twice the depth.
   assign slot_sum = SUM_W'(sel_head) + SUM_W'(sel_count);
   assign slot     = (slot_sum >= SUM_W'(RUN_DEPTH)) ?
                     PTR_W'(slot_sum - SUM_W'(RUN_DEPTH)) : PTR_W'(slot_sum);

   assign ram_waddr = ADDR_W'(run_ff) * ADDR_W'(RUN_DEPTH) + ADDR_W'(slot);
   assign ram_raddr = ADDR_W'(scan_ff) * ADDR_W'(RUN_DEPTH) + ADDR_W'(sel_head);

   always_comb begin
      state_in       = state_ff;
      run_in         = run_ff;
      value_in       = value_ff;
      scan_in        = scan_ff;
      cand_valid_in  = cand_valid_ff;
      cand_way_in    = cand_way_ff;
      found_in       = found_ff;
      best_way_in    = best_way_ff;
      best_val_in    = best_val_ff;
      res_value_in   = res_value_ff;
      res_run_in     = res_run_ff;
      res_status_in  = res_status_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_run_in     = rsp_run_ff;
      rsp_status_in  = rsp_status_ff;
      head_in        = head_ff;
      count_in       = count_ff;
      active_ways_in = csr_wr_en ? csr_wr_data : active_ways_ff;
      ram_we         = 1'b0;
      ram_re         = 1'b0;

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      // Compare the head read last cycle against the best so far; strict less keeps
      // the lower run on a tie.
      if ((state_ff inside {S_SCAN, S_LAST}) && cand_valid_ff) begin
         if (!found_ff || ($signed(ram_rdata) < $signed(best_val_ff))) begin
            found_in    = 1'b1;
            best_way_in = cand_way_ff;
            best_val_in = ram_rdata;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               run_in        = req_if.run_index;
               value_in      = req_if.value;
               scan_in       = '0;
               cand_valid_in = 1'b0;
               found_in      = 1'b0;
               res_value_in  = '0;
               res_run_in    = '0;
               res_status_in = ST_OK;
               case (cmd_type'(req_if.cmd))
                  CMD_PUSH:  state_in = S_PUSH;
                  CMD_POP:   state_in = S_SCAN;
                  CMD_CLEAR: state_in = S_CLEAR;
                  default:   state_in = S_DONE;
               endcase
            end
         end
         S_PUSH: begin
            if (CFG_W'(run_ff) >= k_ways) begin
               res_status_in = ST_RANGE;
            end else if (sel_count >= CNT_W'(RUN_DEPTH)) begin
               res_status_in = ST_FULL;
            end else begin
               ram_we            = 1'b1;
               count_in[sel_idx] = sel_count + CNT_W'(1);
            end
            state_in = S_DONE;
         end
         S_CLEAR: begin
            for (int i = 0; i < WAYS; i++) begin
               head_in[i]  = '0;
               count_in[i] = '0;
            end
            state_in = S_DONE;
         end
         S_SCAN: begin
            // Issue the head read of this way; its data arrives next cycle.
            ram_re        = (sel_count != '0);
            cand_valid_in = (sel_count != '0);
            cand_way_in   = scan_ff;
            if (scan_ff == k_last) begin
               state_in = S_LAST;
            end else begin
               scan_in = scan_ff + WAY_W'(1);
            end
         end
         S_LAST: begin
            cand_valid_in = 1'b0;
            if (found_in) begin
               state_in = S_TAKE;
            end else begin
               res_status_in = ST_EMPTY;
               state_in      = S_DONE;
            end
         end
         S_TAKE: begin
            head_in[sel_idx]  = (sel_head == PTR_W'(RUN_DEPTH - 1)) ?
                                '0 : sel_head + PTR_W'(1);
            count_in[sel_idx] = sel_count - CNT_W'(1);
            res_value_in      = best_val_ff;
            res_run_in        = best_way_ff;
            res_status_in     = ST_OK;
            state_in          = S_DONE;
         end
         S_DONE: begin
            // Hold the result until the output register is free.
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = res_value_ff;
               rsp_run_in    = res_run_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         cand_valid_ff  <= 1'b0;
         found_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         active_ways_ff <= ACTIVE_WAYS_RESET;
         for (int i = 0; i < WAYS; i++) begin
            head_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         state_ff       <= state_in;
         cand_valid_ff  <= cand_valid_in;
         found_ff       <= found_in;
         rsp_valid_ff   <= rsp_valid_in;
         active_ways_ff <= active_ways_in;
         head_ff        <= head_in;
         count_ff       <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      run_ff        <= run_in;
      value_ff      <= value_in;
      scan_ff       <= scan_in;
      cand_way_ff   <= cand_way_in;
      best_way_ff   <= best_way_in;
      best_val_ff   <= best_val_in;
      res_value_ff  <= res_value_in;
      res_run_ff    <= res_run_in;
      res_status_ff <= res_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_run_ff    <= rsp_run_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_if.ready        = (state_ff == S_IDLE);
   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.result_value = rsp_value_ff;
   assign rsp_if.source_run   = rsp_run_ff;
   assign rsp_if.status       = rsp_status_ff;

   `KWM_ASSERT_NOW(a_push_not_full, ram_we, sel_count < CNT_W'(RUN_DEPTH), "push into full run")
   `KWM_ASSERT_NOW(a_take_nonempty, state_ff == S_TAKE, count_ff[best_way_ff] != '0, "empty take")
   `KWM_ASSERT_NOW(a_scan_in_range, state_ff == S_SCAN, scan_ff <= k_last, "scan past ways")
   `KWM_ASSERT_NEXT(a_accept_leaves_idle, req_if.valid && req_if.ready, state_ff != S_IDLE, "stuck")
   `KWM_ASSERT_NOW(a_empty_zero, rsp_valid_ff && rsp_status_ff == ST_EMPTY, rsp_value_ff == '0 && rsp_run_ff == '0, "empty data")

endmodule
